@@ sv/iso14443a_tag_anticollision_top_defines.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the ISO14443-A tag anticollision block
// Clocked concurrent assertions with and without a reset qualifier.
// ----------------------------------------------------------------------------
`ifndef ISO14443A_TAG_ANTICOLLISION_TOP_DEFINES_SVH
`define ISO14443A_TAG_ANTICOLLISION_TOP_DEFINES_SVH

`ifndef ASSERT_OFF
`define ISOA_ASSERT(lbl, clk, rstn, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
`define ISOA_ASSERT_NR(lbl, clk, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define ISOA_ASSERT(lbl, clk, rstn, prop, msg)
`define ISOA_ASSERT_NR(lbl, clk, prop, msg)
`endif

`endif

@@ sv/isoa_pkg.sv @@
// ----------------------------------------------------------------------------
// ISO14443-A tag anticollision package
// Protocol codes, shared types and the cascade level record builder.
// ----------------------------------------------------------------------------
package isoa_pkg;

	localparam logic [1:0] ST_IDLE     = 2'd0;
	localparam logic [1:0] ST_WOKEN    = 2'd1;
	localparam logic [1:0] ST_SELECTED = 2'd2;

	localparam logic [1:0] CFG_ATQA    = 2'd0;
	localparam logic [1:0] CFG_SAK     = 2'd1;
	localparam logic [1:0] CFG_UID_LOW = 2'd2;
	localparam logic [1:0] CFG_UID_HI  = 2'd3;

	localparam logic [7:0] CMD_REQ_IDLE   = 8'h26;
	localparam logic [7:0] CMD_REQ_WAKE   = 8'h52;
	localparam logic [7:0] CMD_SEL_CL1    = 8'h93;
	localparam logic [7:0] NVB_FULL       = 8'h70;
	localparam logic [7:0] CASCADE_TAG    = 8'h88;
	localparam logic [7:0] SAK_INCOMPLETE = 8'h04;
	localparam logic [1:0] TOP_LEVEL_MAX  = 2'd2;

	localparam int REC_BYTES   = 7;
	localparam int REPLY_BYTES = 5;

	typedef struct packed {
		logic [1:0] pstate;
		logic [1:0] level;
	} ctl_t;

	typedef struct packed {
		logic [2:0]                   len;
		logic [REPLY_BYTES-1:0][7:0] data;
	} reply_t;

	function automatic logic [REC_BYTES-1:0][7:0] level_record(
		input logic [1:0]  level,
		input logic [1:0]  top,
		input logic [79:0] uid
	);
		logic [REC_BYTES-1:0][7:0] rec;
		logic [3:0]                idx;
		logic [79:0]               sh;
		rec    = '0;
		rec[0] = CMD_SEL_CL1 + {5'd0, level, 1'b0};
		rec[1] = NVB_FULL;
		idx    = {1'b0, level, 1'b0} + {2'd0, level};
		sh     = uid >> {idx, 3'b000};
		if (level < top) begin
			rec[2] = CASCADE_TAG;
			rec[3] = sh[7:0];
			rec[4] = sh[15:8];
			rec[5] = sh[23:16];
		end else begin
			rec[2] = sh[7:0];
			rec[3] = sh[15:8];
			rec[4] = sh[23:16];
			rec[5] = sh[31:24];
		end
		rec[6] = rec[2] ^ rec[3] ^ rec[4] ^ rec[5];
		return rec;
	endfunction

endpackage

@@ sv/isoa_if.sv @@
// ----------------------------------------------------------------------------
// ISO14443-A tag anticollision channel interfaces
// Received frame channel and reply channel, each with valid and ready.
// ----------------------------------------------------------------------------
interface isoa_frame_if;
	logic       valid;
	logic       ready;
	logic [7:0] frame_length;
	logic [7:0] frame_byte0;
	logic [7:0] frame_byte1;
	logic [7:0] frame_byte2;
	logic [7:0] frame_byte3;
	logic [7:0] frame_byte4;
	logic [7:0] frame_byte5;
	logic [7:0] frame_byte6;

	modport source (output valid, frame_length, frame_byte0, frame_byte1, frame_byte2,
		frame_byte3, frame_byte4, frame_byte5, frame_byte6, input ready);
	modport sink (input valid, frame_length, frame_byte0, frame_byte1, frame_byte2,
		frame_byte3, frame_byte4, frame_byte5, frame_byte6, output ready);
endinterface

interface isoa_reply_if;
	logic       valid;
	logic       ready;
	logic [2:0] reply_length;
	logic [7:0] reply_byte0;
	logic [7:0] reply_byte1;
	logic [7:0] reply_byte2;
	logic [7:0] reply_byte3;
	logic [7:0] reply_byte4;

	modport source (output valid, reply_length, reply_byte0, reply_byte1, reply_byte2,
		reply_byte3, reply_byte4, input ready);
	modport sink (input valid, reply_length, reply_byte0, reply_byte1, reply_byte2,
		reply_byte3, reply_byte4, output ready);
endinterface

@@ sv/isoa_lane.sv @@
// ----------------------------------------------------------------------------
// ISO14443-A byte compare lane
// Compares one received byte with one record byte, in full and under the
// partial-byte mask of the anticollision bit count.
// ----------------------------------------------------------------------------
module isoa_lane (
	input  logic [7:0] frame_b,
	input  logic [7:0] rec_b,
	input  logic [7:0] mask,
	output logic       eq,
	output logic       part
);

	logic [7:0] diff;

	assign diff = frame_b ^ rec_b;
	assign eq   = (diff == 8'h00);
	assign part = ((diff & mask) == 8'h00);

endmodule

@@ sv/isoa_merge.sv @@
// ----------------------------------------------------------------------------
// ISO14443-A lane merge and protocol decision
// Combines the lane results with the protocol state to form the reply and
// the next state.
// ----------------------------------------------------------------------------
module isoa_merge import isoa_pkg::*; (
	input  ctl_t                       ctl,
	input  logic [1:0]                 top_lvl,
	input  logic [7:0]                 frame_length,
	input  logic [7:0]                 cmd,
	input  logic [7:0]                 nvb,
	input  logic [REC_BYTES-1:0]       eq,
	input  logic [REC_BYTES-1:0]       part,
	input  logic [REPLY_BYTES-1:0][7:0] rec_tail,
	input  logic [15:0]                atqa,
	input  logic [7:0]                 sak,
	output reply_t                     reply,
	output ctl_t                       ctl_nxt
);

	logic [3:0]                 n_bytes;
	logic [3:0]                 n_bits;
	logic [4:0]                 cnt;
	logic                       nvb_ok;
	logic                       prefix_ok;
	logic                       part_ok;
	logic                       ac_ok;
	logic                       full_ok;
	logic [7:0]                 part_pad;
	logic [2:0]                 sh_amt;
	logic [REPLY_BYTES*8-1:0]   tail_sh;

	assign n_bytes  = nvb[7:4];
	assign n_bits   = nvb[3:0];
	assign cnt      = {1'b0, n_bytes} + {4'd0, (n_bits != 4'd0)};
	assign nvb_ok   = (n_bits <= 4'd7) && (n_bytes >= 4'd2) && (n_bytes <= 4'd6);
	assign part_pad = {1'b0, part};
	assign part_ok  = (n_bits == 4'd0) || part_pad[n_bytes[2:0]];
	assign sh_amt   = n_bytes[2:0] - 3'd2;
	assign tail_sh  = rec_tail >> {sh_amt, 3'b000};
	assign full_ok  = (frame_length == 8'd7) && (&eq);

	always_comb begin
		prefix_ok = 1'b1;
		for (int k = 2; k < REC_BYTES; k++) begin
			if ((4'(k) < n_bytes) && !eq[k]) begin
				prefix_ok = 1'b0;
			end
		end
	end

	assign ac_ok = eq[0] && nvb_ok && ({3'd0, cnt} == frame_length) && prefix_ok && part_ok;

	always_comb begin
		reply   = '0;
		ctl_nxt = '{pstate: ST_IDLE, level: ctl.level};
		priority if (ctl.pstate == ST_IDLE) begin
			if ((frame_length == 8'd1) && ((cmd == CMD_REQ_IDLE) || (cmd == CMD_REQ_WAKE))) begin
				reply.len     = 3'd2;
				reply.data[0] = atqa[7:0];
				reply.data[1] = atqa[15:8];
				ctl_nxt       = '{pstate: ST_WOKEN, level: 2'd0};
			end
		end else if ((ctl.pstate == ST_WOKEN) && (ctl.level <= top_lvl)) begin
			if (full_ok) begin
				reply.len = 3'd1;
				if (ctl.level == top_lvl) begin
					reply.data[0] = sak;
					ctl_nxt       = '{pstate: ST_SELECTED, level: ctl.level};
				end else begin
					reply.data[0] = sak | SAK_INCOMPLETE;
					ctl_nxt       = '{pstate: ST_WOKEN, level: ctl.level + 2'd1};
				end
			end else if (ac_ok) begin
				reply.len  = 3'd7 - n_bytes[2:0];
				reply.data = tail_sh;
				ctl_nxt    = '{pstate: ST_WOKEN, level: ctl.level};
			end
		end else begin
			reply = '0;
		end
	end

endmodule

@@ sv/iso14443a_tag_anticollision_top.sv @@
// ----------------------------------------------------------------------------
// ISO14443-A tag anticollision and select, top level
// Answers REQA/WUPA, anticollision and select frames per cascade level.
//
//   channel  direction  carries
//   rx       in         one received frame: length and seven bytes
//   tx       out        one reply: length and five bytes
//   cfg_*    in         register writes: ATQA, SAK, UID bytes
//
// Seven compare lanes and the merge stage work in the cycle of acceptance,
// and the reply lands in the output register, or in the skid entry if busy.
// A new item is accepted in every cycle; a two-entry output buffer lets one
// more item in while a reply waits on tx, after which rx.ready drops.
// Reset clears the protocol state, cascade level, config and valid flags.
// ----------------------------------------------------------------------------
`include "iso14443a_tag_anticollision_top_defines.svh"

module iso14443a_tag_anticollision_top import isoa_pkg::*; (
	input  logic          clk,
	input  logic          arst_n,
	isoa_frame_if.sink    rx,
	isoa_reply_if.source  tx,
	input  logic          cfg_we,
	input  logic [1:0]    cfg_index,
	input  logic [63:0]   cfg_data
);

	logic [15:0]                  atqa_q;
	logic [7:0]                   sak_q;
	logic [63:0]                  uid_low_q;
	logic [15:0]                  uid_high_q;
	ctl_t                         ctl_q;
	ctl_t                         ctl_nxt;
	logic [1:0]                   top_lvl;
	logic [REC_BYTES-1:0][7:0]    rec;
	logic [REC_BYTES-1:0][7:0]    fb;
	logic [7:0]                   mask;
	logic [REC_BYTES-1:0]         eq;
	logic [REC_BYTES-1:0]         part;
	reply_t                       reply;
	reply_t                       out_q;
	reply_t                       skid_q;
	logic                         out_v_q;
	logic                         skid_v_q;
	logic                         in_fire;
	logic                         out_fire;

	assign fb[0] = rx.frame_byte0;
	assign fb[1] = rx.frame_byte1;
	assign fb[2] = rx.frame_byte2;
	assign fb[3] = rx.frame_byte3;
	assign fb[4] = rx.frame_byte4;
	assign fb[5] = rx.frame_byte5;
	assign fb[6] = rx.frame_byte6;

	assign top_lvl = (atqa_q[7:6] > TOP_LEVEL_MAX) ? TOP_LEVEL_MAX : atqa_q[7:6];
	assign rec     = level_record(ctl_q.level, top_lvl, {uid_high_q, uid_low_q});
	assign mask    = ~(8'hFF << fb[1][2:0]);

	for (genvar j = 0; j < REC_BYTES; j++) begin : g_lane
		isoa_lane u_lane (
			.frame_b (fb[j]),
			.rec_b   (rec[j]),
			.mask    (mask),
			.eq      (eq[j]),
			.part    (part[j])
		);
	end

	isoa_merge u_merge (
		.ctl          (ctl_q),
		.top_lvl      (top_lvl),
		.frame_length (rx.frame_length),
		.cmd          (fb[0]),
		.nvb          (fb[1]),
		.eq           (eq),
		.part         (part),
		.rec_tail     (rec[REC_BYTES-1:2]),
		.atqa         (atqa_q),
		.sak          (sak_q),
		.reply        (reply),
		.ctl_nxt      (ctl_nxt)
	);

	assign rx.ready = !skid_v_q;
	assign in_fire  = rx.valid && !skid_v_q;
	assign out_fire = out_v_q && tx.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			atqa_q     <= '0;
			sak_q      <= '0;
			uid_low_q  <= '0;
			uid_high_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_ATQA:    atqa_q     <= cfg_data[15:0];
				CFG_SAK:     sak_q      <= cfg_data[7:0];
				CFG_UID_LOW: uid_low_q  <= cfg_data;
				CFG_UID_HI:  uid_high_q <= cfg_data[15:0];
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_q <= '{pstate: ST_IDLE, level: 2'd0};
		end else if (in_fire) begin
			ctl_q <= ctl_nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q  <= 1'b0;
			skid_v_q <= 1'b0;
		end else if (out_fire || !out_v_q) begin
			out_v_q  <= skid_v_q || in_fire;
			skid_v_q <= 1'b0;
		end else if (in_fire) begin
			skid_v_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (out_fire || !out_v_q) begin
			out_q <= skid_v_q ? skid_q : reply;
		end else if (in_fire) begin
			skid_q <= reply;
		end
	end

	assign tx.valid        = out_v_q;
	assign tx.reply_length = out_q.len;
	assign tx.reply_byte0  = out_q.data[0];
	assign tx.reply_byte1  = out_q.data[1];
	assign tx.reply_byte2  = out_q.data[2];
	assign tx.reply_byte3  = out_q.data[3];
	assign tx.reply_byte4  = out_q.data[4];

	`ISOA_ASSERT(a_skid_behind_out, clk, arst_n, skid_v_q |-> out_v_q, "skid item alone")
	`ISOA_ASSERT(a_level_bound, clk, arst_n,
		ctl_q.pstate == ST_WOKEN |-> ctl_q.level <= TOP_LEVEL_MAX, "level beyond top")
	`ISOA_ASSERT(a_active_by_select, clk, arst_n,
		in_fire && ctl_nxt.pstate == ST_SELECTED |-> reply.len == 3'd1, "selected, no SAK")
	`ISOA_ASSERT(a_active_leaves, clk, arst_n,
		in_fire && ctl_q.pstate == ST_SELECTED |=> ctl_q.pstate == ST_IDLE, "selected state kept")

endmodule

@@ sim/iso14443a_tag_anticollision_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Reply checker for the ISO14443-A tag anticollision block
// Watches the frame, reply and register ports. For every accepted frame it
// works out the reply the card should give, from its own copy of the
// registers, the protocol state and the cascade level, and queues it. Every
// accepted reply is compared field by field with the oldest queued reply.
// ----------------------------------------------------------------------------
module iso14443a_tag_anticollision_checker import isoa_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	isoa_frame_if        rx,
	isoa_reply_if        tx,
	input  logic         cfg_we,
	input  logic [1:0]   cfg_index,
	input  logic [63:0]  cfg_data,
	output int           fail_count,
	output int           replies_owed
);

	logic [15:0] atqa;
	logic [7:0]  sak;
	logic [79:0] uid;
	logic [1:0]  pstate;
	logic [1:0]  level;
	reply_t      owed_replies[$];

	function automatic logic [REC_BYTES-1:0][7:0] select_record(input logic [1:0] lvl,
		input logic [1:0] top_lvl);
		logic [REC_BYTES-1:0][7:0] rec;
		int k;
		int j;
		rec    = '0;
		rec[0] = CMD_SEL_CL1 + 8'(2 * lvl);
		rec[1] = NVB_FULL;
		k      = 3 * lvl;
		j      = 2;
		if (lvl < top_lvl) begin
			rec[2] = CASCADE_TAG;
			j      = 3;
		end
		while (j < 6) begin
			rec[j] = uid[8 * k +: 8];
			k++;
			j++;
		end
		rec[6] = rec[2] ^ rec[3] ^ rec[4] ^ rec[5];
		return rec;
	endfunction

	task automatic answer_frame(input logic [7:0] len, input logic [REC_BYTES-1:0][7:0] fb);
		reply_t                    r;
		logic [REC_BYTES-1:0][7:0] rec;
		logic [1:0]                top_lvl;
		logic [3:0]                nbytes;
		logic [3:0]                nbits;
		logic [7:0]                mask;
		logic                      to_idle;
		logic                      hit;
		int                        i;
		r       = '0;
		to_idle = 1'b1;
		top_lvl = (atqa[7:6] > TOP_LEVEL_MAX) ? TOP_LEVEL_MAX : atqa[7:6];
		case (pstate)
		ST_IDLE: begin
			if (len == 8'd1 && (fb[0] == CMD_REQ_IDLE || fb[0] == CMD_REQ_WAKE)) begin
				pstate    = ST_WOKEN;
				level     = 2'd0;
				r.len     = 3'd2;
				r.data[0] = atqa[7:0];
				r.data[1] = atqa[15:8];
				to_idle   = 1'b0;
			end
		end
		ST_WOKEN: begin
			if (level <= top_lvl) begin
				rec = select_record(level, top_lvl);
				if (len == 8'd7 && fb == rec) begin
					r.len   = 3'd1;
					to_idle = 1'b0;
					if (level == top_lvl) begin
						r.data[0] = sak;
						pstate    = ST_SELECTED;
					end else begin
						r.data[0] = sak | SAK_INCOMPLETE;
						level     = level + 2'd1;
					end
				end else if (fb[0] == rec[0]) begin
					nbytes = fb[1][7:4];
					nbits  = fb[1][3:0];
					if (nbits <= 4'd7 && nbytes >= 4'd2 && nbytes <= 4'd6 &&
							len == {4'd0, nbytes} + {7'd0, nbits != 4'd0}) begin
						hit = 1'b1;
						for (i = 2; i < nbytes; i++)
							if (fb[i] != rec[i])
								hit = 1'b0;
						if (nbits != 4'd0) begin
							mask = 8'((1 << nbits) - 1);
							if (((rec[nbytes] ^ fb[len - 8'd1]) & mask) != 8'd0)
								hit = 1'b0;
						end
						if (hit) begin
							r.len   = 3'(7 - nbytes);
							to_idle = 1'b0;
							for (i = 0; i < REPLY_BYTES; i++)
								if (i < 7 - nbytes)
									r.data[i] = rec[nbytes + i];
						end
					end
				end
			end
		end
		default: ;
		endcase
		if (to_idle)
			pstate = ST_IDLE;
		owed_replies.push_back(r);
	endtask

	always @(posedge clk or negedge arst_n) begin
		reply_t got;
		reply_t want;
		logic   bad;
		int     i;
		if (!arst_n) begin
			atqa       = '0;
			sak        = '0;
			uid        = '0;
			pstate     = ST_IDLE;
			level      = 2'd0;
			fail_count = 0;
			owed_replies.delete();
		end else begin
			if (tx.valid && tx.ready) begin
				got.len  = tx.reply_length;
				got.data = {tx.reply_byte4, tx.reply_byte3, tx.reply_byte2,
					tx.reply_byte1, tx.reply_byte0};
				if (owed_replies.size() == 0) begin
					fail_count++;
					if (fail_count <= 10)
						$display("%0t: reply with no frame outstanding, got len %0d data %h",
							$realtime, got.len, got.data);
				end else begin
					want = owed_replies.pop_front();
					bad  = (got.len !== want.len);
					for (i = 0; i < REPLY_BYTES; i++)
						if (got.data[i] !== want.data[i])
							bad = 1'b1;
					if (bad) begin
						fail_count++;
						if (fail_count <= 10)
							$display("%0t: reply mismatch, expected len %0d data %h, got len %0d data %h",
								$realtime, want.len, want.data, got.len, got.data);
					end
				end
			end
			if (cfg_we) begin
				case (cfg_index)
				CFG_ATQA:    atqa        = cfg_data[15:0];
				CFG_SAK:     sak         = cfg_data[7:0];
				CFG_UID_LOW: uid[63:0]   = cfg_data;
				CFG_UID_HI:  uid[79:64]  = cfg_data[15:0];
				default: ;
				endcase
			end
			if (rx.valid && rx.ready)
				answer_frame(rx.frame_length, {rx.frame_byte6, rx.frame_byte5, rx.frame_byte4,
					rx.frame_byte3, rx.frame_byte2, rx.frame_byte1, rx.frame_byte0});
		end
		replies_owed = owed_replies.size();
	end

endmodule

@@ sim/iso14443a_tag_anticollision_top_test.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Testbench for the ISO14443-A tag anticollision block
// Sends received frames to the card: a short directed sequence through every
// command, the cascade levels and the rejection cases, then phases of random
// anticollision and select sessions mixed with broken frames and noise, each
// phase under its own register setting. Both channels idle at random, the
// reply side once holds off long enough to stall the frame side, and the
// checker beside the block predicts and compares every reply.
// ----------------------------------------------------------------------------
module iso14443a_tag_anticollision_top_test;
	import isoa_pkg::*;

	localparam int CYCLE_LIMIT  = 200000;
	localparam int HOLD_CYCLES  = 80;
	localparam int PHASES       = 12;
	localparam int PHASE_FRAMES = 138;

	typedef struct packed {
		logic [7:0]                len;
		logic [REC_BYTES-1:0][7:0] data;
	} frame_t;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        cfg_we;
	logic [1:0]  cfg_index;
	logic [63:0] cfg_data;
	int          fail_count;
	int          replies_owed;
	int          cycles = 0;
	bit          rx_steady;
	bit          tx_steady;
	bit          hold_tx;
	logic [15:0] atqa_shadow;
	logic [79:0] uid_shadow;
	frame_t      frame_q[$];

	isoa_frame_if rx();
	isoa_reply_if tx();

	iso14443a_tag_anticollision_top uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.rx        (rx),
		.tx        (tx),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	iso14443a_tag_anticollision_checker chk (
		.clk          (clk),
		.arst_n       (arst_n),
		.rx           (rx),
		.tx           (tx),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.fail_count   (fail_count),
		.replies_owed (replies_owed)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CYCLE_LIMIT) begin
			$display("Regression FAIL");
			$finish;
		end
	end

	// Cascade level record as the card should hold it for the current registers.
	function automatic logic [REC_BYTES-1:0][7:0] level_bytes(input logic [1:0] lvl);
		logic [REC_BYTES-1:0][7:0] rec;
		logic [1:0]                top_lvl;
		int                        k;
		int                        j;
		top_lvl = (atqa_shadow[7:6] > TOP_LEVEL_MAX) ? TOP_LEVEL_MAX : atqa_shadow[7:6];
		rec[0]  = CMD_SEL_CL1 + 8'(2 * lvl);
		rec[1]  = NVB_FULL;
		k       = 3 * lvl;
		j       = 2;
		if (lvl < top_lvl) begin
			rec[2] = CASCADE_TAG;
			j      = 3;
		end
		while (j < 6) begin
			rec[j] = uid_shadow[8 * k +: 8];
			k++;
			j++;
		end
		rec[6] = rec[2] ^ rec[3] ^ rec[4] ^ rec[5];
		return rec;
	endfunction

	function automatic frame_t req_frame(input logic [7:0] cmd);
		frame_t f;
		f.data    = 56'({$urandom, $urandom});
		f.data[0] = cmd;
		f.len     = 8'd1;
		return f;
	endfunction

	function automatic frame_t sel_frame(input logic [1:0] lvl);
		frame_t f;
		f.data = level_bytes(lvl);
		f.len  = 8'd7;
		return f;
	endfunction

	function automatic frame_t sdd_frame(input logic [1:0] lvl, input int nb, input int nbit);
		frame_t                    f;
		logic [REC_BYTES-1:0][7:0] rec;
		logic [7:0]                mask;
		int                        i;
		rec       = level_bytes(lvl);
		f.data    = 56'({$urandom, $urandom});
		f.data[0] = rec[0];
		f.data[1] = {4'(nb), 4'(nbit)};
		for (i = 2; i < nb; i++)
			f.data[i] = rec[i];
		if (nbit != 0) begin
			mask      = 8'((1 << nbit) - 1);
			f.data[nb] = (rec[nb] & mask) | (f.data[nb] & ~mask);
		end
		f.len = 8'(nb + (nbit != 0));
		return f;
	endfunction

	function automatic frame_t broken_frame(input logic [1:0] lvl);
		frame_t f;
		int     nb;
		int     k;
		f  = sel_frame(lvl);
		nb = $urandom_range(2, 6);
		case ($urandom_range(0, 3))
		0: begin
			k         = $urandom_range(0, 6);
			f.data[k] = f.data[k] ^ (8'd1 << $urandom_range(0, 7));
		end
		1: f.len = 8'($urandom_range(0, 6));
		2: begin
			f              = sdd_frame(lvl, nb, 0);
			f.data[1][3:0] = 4'($urandom_range(8, 15));
			f.len          = 8'(nb + 1);
		end
		default: f.data[0] = f.data[0] + 8'd2;
		endcase
		return f;
	endfunction

	function automatic frame_t noise_frame();
		frame_t f;
		f.data = 56'({$urandom, $urandom});
		f.len  = ($urandom_range(0, 7) == 0) ? 8'($urandom) : 8'($urandom_range(0, 8));
		case ($urandom_range(0, 3))
		0: f.data[0] = ($urandom_range(0, 1) == 0) ? CMD_REQ_IDLE : CMD_REQ_WAKE;
		1: f.data[0] = CMD_SEL_CL1 + 8'(2 * $urandom_range(0, 2));
		default: ;
		endcase
		return f;
	endfunction

	// One card session: wake-up, anticollision rounds and select on each level.
	// A broken session ends on a damaged frame at a random level.
	task automatic queue_session(input bit broken);
		logic [1:0] top_lvl;
		int         lvl;
		int         cut;
		top_lvl = (atqa_shadow[7:6] > TOP_LEVEL_MAX) ? TOP_LEVEL_MAX : atqa_shadow[7:6];
		cut     = $urandom_range(0, top_lvl);
		frame_q.push_back(req_frame(($urandom_range(0, 1) == 0) ? CMD_REQ_IDLE : CMD_REQ_WAKE));
		for (lvl = 0; lvl <= top_lvl; lvl++) begin
			repeat ($urandom_range(0, 2))
				frame_q.push_back(sdd_frame(2'(lvl), $urandom_range(2, 6), $urandom_range(0, 7)));
			if (broken && lvl == cut) begin
				frame_q.push_back(broken_frame(2'(lvl)));
				return;
			end
			frame_q.push_back(sel_frame(2'(lvl)));
		end
		if ($urandom_range(0, 3) == 0)
			frame_q.push_back(noise_frame());
	endtask

	task automatic send_frame(input frame_t f);
		int gap;
		gap = rx_steady ? 0 : $urandom_range(0, 10);
		if (gap > 0) begin
			rx.valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		rx.valid        <= 1'b1;
		rx.frame_length <= f.len;
		rx.frame_byte0  <= f.data[0];
		rx.frame_byte1  <= f.data[1];
		rx.frame_byte2  <= f.data[2];
		rx.frame_byte3  <= f.data[3];
		rx.frame_byte4  <= f.data[4];
		rx.frame_byte5  <= f.data[5];
		rx.frame_byte6  <= f.data[6];
		do @(posedge clk); while (!rx.ready);
		@(negedge clk);
	endtask

	task automatic drain_frames();
		while (frame_q.size() > 0)
			send_frame(frame_q.pop_front());
	endtask

	// Stops sending and waits for every owed reply before the registers change.
	task automatic settle();
		rx.valid <= 1'b0;
		wait (replies_owed == 0);
		repeat (4) @(negedge clk);
	endtask

	task automatic write_reg(input logic [1:0] idx, input logic [63:0] value);
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= value;
		@(negedge clk);
		cfg_we    <= 1'b0;
		case (idx)
		CFG_ATQA:    atqa_shadow       = value[15:0];
		CFG_UID_LOW: uid_shadow[63:0]  = value;
		CFG_UID_HI:  uid_shadow[79:64] = value[15:0];
		default: ;
		endcase
	endtask

	task automatic configure(input int phase);
		logic [63:0] atqa_w;
		logic [63:0] sak_w;
		logic [63:0] low_w;
		logic [63:0] high_w;
		atqa_w      = {$urandom, $urandom};
		sak_w       = {$urandom, $urandom};
		low_w       = {$urandom, $urandom};
		high_w      = {$urandom, $urandom};
		atqa_w[7:6] = 2'(phase);
		if (phase == 0) begin
			atqa_w = '0;
			sak_w  = '0;
			low_w  = '0;
			high_w = '0;
		end else if (phase == 1) begin
			atqa_w = '1;
			sak_w  = '1;
			low_w  = '1;
			high_w = '1;
		end
		settle();
		write_reg(CFG_ATQA, atqa_w);
		write_reg(CFG_SAK, sak_w);
		write_reg(CFG_UID_LOW, low_w);
		write_reg(CFG_UID_HI, high_w);
	endtask

	initial begin : reply_side
		int gap;
		@(posedge arst_n);
		forever begin
			if (hold_tx) begin
				tx.ready <= 1'b0;
				repeat (HOLD_CYCLES) @(negedge clk);
				hold_tx = 1'b0;
			end
			gap = tx_steady ? 0 : $urandom_range(0, 10);
			if (gap > 0) begin
				tx.ready <= 1'b0;
				repeat (gap) @(negedge clk);
			end
			tx.ready <= 1'b1;
			do @(posedge clk); while (!tx.valid);
			@(negedge clk);
		end
	end

	initial begin : frame_side
		frame_t f;
		int     phase;
		arst_n          = 1'b0;
		cfg_we          = 1'b0;
		cfg_index       = CFG_ATQA;
		cfg_data        = '0;
		rx.valid        = 1'b0;
		rx.frame_length = '0;
		rx.frame_byte0  = '0;
		rx.frame_byte1  = '0;
		rx.frame_byte2  = '0;
		rx.frame_byte3  = '0;
		rx.frame_byte4  = '0;
		rx.frame_byte5  = '0;
		rx.frame_byte6  = '0;
		tx.ready        = 1'b0;
		rx_steady       = 1'b0;
		tx_steady       = 1'b0;
		hold_tx         = 1'b0;
		atqa_shadow     = '0;
		uid_shadow      = '0;
		repeat (4) @(negedge clk);
		arst_n <= 1'b1;

		// With the registers as reset leaves them there is one level of zeros.
		frame_q.push_back(req_frame(CMD_REQ_IDLE));
		frame_q.push_back(sel_frame(2'd0));
		frame_q.push_back(noise_frame());
		drain_frames();
		settle();
		write_reg(CFG_ATQA, 64'h0044);
		write_reg(CFG_SAK, 64'h20);
		write_reg(CFG_UID_LOW, {$urandom, $urandom});
		write_reg(CFG_UID_HI, 64'($urandom));

		f     = req_frame(CMD_REQ_WAKE);
		f.len = 8'd0;
		frame_q.push_back(f);
		f.len     = 8'hFF;
		f.data[0] = CMD_REQ_IDLE;
		frame_q.push_back(f);
		frame_q.push_back(req_frame(CMD_REQ_WAKE));
		frame_q.push_back(sdd_frame(2'd0, 2, 0));
		frame_q.push_back(sdd_frame(2'd0, 3, 5));
		f         = sdd_frame(2'd0, 2, 0);
		f.data[1] = 8'h28;
		f.len     = 8'd3;
		frame_q.push_back(f);
		frame_q.push_back(req_frame(CMD_REQ_IDLE));
		frame_q.push_back(sel_frame(2'd0));
		frame_q.push_back(sdd_frame(2'd1, 6, 7));
		frame_q.push_back(sel_frame(2'd1));
		frame_q.push_back(noise_frame());
		frame_q.push_back(req_frame(CMD_REQ_IDLE));
		f         = sdd_frame(2'd0, 2, 0);
		f.data[0] = 8'h95;
		frame_q.push_back(f);
		frame_q.push_back(req_frame(CMD_REQ_IDLE));
		frame_q.push_back(sel_frame(2'd0));
		drain_frames();

		// The card now waits on level one; lowering the UID size leaves it above the top.
		settle();
		write_reg(CFG_ATQA, 64'h0004);
		frame_q.push_back(sdd_frame(2'd1, 2, 0));
		drain_frames();

		for (phase = 0; phase < PHASES; phase++) begin
			configure(phase);
			rx_steady = ($urandom_range(0, 3) == 0);
			tx_steady = ($urandom_range(0, 3) == 0);
			if (phase == 4) begin
				rx_steady = 1'b1;
				hold_tx   = 1'b1;
			end
			while (frame_q.size() < PHASE_FRAMES) begin
				if ($urandom_range(0, 9) < 7)
					queue_session($urandom_range(0, 3) == 0);
				else
					frame_q.push_back(noise_frame());
			end
			drain_frames();
		end

		settle();
		repeat (20) @(negedge clk);
		if (fail_count == 0 && replies_owed == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule

@@ filelist.f @@
+incdir+sv
sv/isoa_pkg.sv
sv/isoa_if.sv
sv/isoa_lane.sv
sv/isoa_merge.sv
sv/iso14443a_tag_anticollision_top.sv
sim/iso14443a_tag_anticollision_checker.sv
sim/iso14443a_tag_anticollision_top_test.sv
